// ===== sv/itrd_pkg.sv =====
// shared constants, state type and digit glyph mapping for the radix digit converter
package itrd_pkg;

  localparam int unsigned RADIX_W   = 6;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned MIN_RADIX = 2;
  localparam int unsigned MAX_RADIX = 36;
  localparam int unsigned MAX_DIGIT = MAX_RADIX - 1;
  // bits of the dividend retired per division cycle
  localparam int unsigned BITS_PER_CYCLE = 8;

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOW_A  = 8'h61;
  localparam logic [CHAR_W-1:0] DECIMAL_TOP = 8'd10;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_READ = 4'b0100,
    ST_EMIT = 4'b1000
  } back_state_e;

  // digit value to "0123456789abcdefghijklmnopqrstuvwxyz"
  function automatic logic [CHAR_W-1:0] digit_glyph(logic [RADIX_W-1:0] d);
    logic [RADIX_W-1:0] c;
    logic [CHAR_W-1:0]  w;
    c = (d > RADIX_W'(MAX_DIGIT)) ? RADIX_W'(MAX_DIGIT) : d;
    w = {{(CHAR_W-RADIX_W){1'b0}}, c};
    if (w < DECIMAL_TOP) begin
      return CHAR_ZERO + w;
    end
    return CHAR_LOW_A + w - DECIMAL_TOP;
  endfunction

endpackage

// ===== sv/itrd_front.sv =====
// front end: masks the value, takes its magnitude and clamps the radix
module itrd_front
  import itrd_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic [63:0]           value_i,
  input  logic                  is_signed_i,
  input  logic [RADIX_W-1:0]    radix_i,
  output logic [VALUE_BITS-1:0] job_mag_o,
  output logic [RADIX_W-1:0]    job_radix_o,
  output logic                  job_neg_o
);

  logic [VALUE_BITS-1:0] v;
  logic                  neg;

  assign v   = value_i[VALUE_BITS-1:0];
  assign neg = is_signed_i & v[VALUE_BITS-1];

  // two's complement magnitude, read as unsigned so the most negative value is fine
  assign job_mag_o = neg ? (~v + VALUE_BITS'(1)) : v;
  assign job_neg_o = neg;

  always_comb begin
    priority if (radix_i < RADIX_W'(MIN_RADIX)) begin
      job_radix_o = RADIX_W'(MIN_RADIX);
    end else if (radix_i > RADIX_W'(MAX_RADIX)) begin
      job_radix_o = RADIX_W'(MAX_RADIX);
    end else begin
      job_radix_o = radix_i;
    end
  end

endmodule

// ===== sv/itrd_queue.sv =====
// two-entry request queue between front end and digit engine
module itrd_queue #(
  parameter int unsigned W = 71
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  logic [W-1:0] slot_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   count_q, count_d;
  logic         push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/itrd_back.sv =====
// digit engine: iterative divide by the radix, digit store, reverse-order emission
module itrd_back
  import itrd_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned MAX_DIGITS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_valid_i,
  output logic                  job_ready_o,
  input  logic [VALUE_BITS-1:0] job_mag_i,
  input  logic [RADIX_W-1:0]    job_radix_i,
  input  logic                  job_neg_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CHAR_W-1:0]     digit_char_o,
  output logic                  negative_o,
  output logic                  last_o
);

  localparam int unsigned CPD   = (VALUE_BITS + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
  localparam int unsigned DIV_W = CPD * BITS_PER_CYCLE;
  localparam int unsigned CW    = (CPD > 1) ? $clog2(CPD) : 1;
  localparam int unsigned AW    = $clog2(MAX_DIGITS);
  localparam int unsigned NW    = $clog2(MAX_DIGITS + 1);

  back_state_e        state_q, state_d;
  logic [DIV_W-1:0]   dvd_q, dvd_d;
  logic [RADIX_W-1:0] rem_q, rem_d;
  logic [RADIX_W-1:0] radix_q, radix_d;
  logic               neg_q, neg_d;
  logic [CW-1:0]      chunk_q, chunk_d;
  logic [NW-1:0]      cnt_q, cnt_d;
  logic [AW-1:0]      idx_q, idx_d;

  logic [DIV_W-1:0]   step_dvd;
  logic [RADIX_W-1:0] step_rem;
  logic               mem_we;

  logic [RADIX_W-1:0] store_q [MAX_DIGITS];
  logic [RADIX_W-1:0] rd_q;

  // eight restoring division steps on the narrow remainder
  always_comb begin
    logic [RADIX_W:0]   t;
    logic [DIV_W-1:0]   d;
    logic [RADIX_W-1:0] r;
    d = dvd_q;
    r = rem_q;
    for (int i = 0; i < BITS_PER_CYCLE; i++) begin
      t = {r, d[DIV_W-1]};
      d = {d[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, radix_q}) begin
        t    = t - {1'b0, radix_q};
        d[0] = 1'b1;
      end
      r = t[RADIX_W-1:0];
    end
    step_dvd = d;
    step_rem = r;
  end

  assign job_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o  = (state_q == ST_EMIT);
  assign digit_char_o = digit_glyph(rd_q);
  assign negative_o   = neg_q;
  assign last_o       = (idx_q == '0);
  assign mem_we       = (state_q == ST_DIV) && (chunk_q == CW'(CPD - 1));

  always_comb begin
    state_d = state_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    radix_d = radix_q;
    neg_d   = neg_q;
    chunk_d = chunk_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          dvd_d   = DIV_W'(job_mag_i);
          radix_d = job_radix_i;
          neg_d   = job_neg_i;
          rem_d   = '0;
          chunk_d = '0;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        dvd_d = step_dvd;
        rem_d = step_rem;
        if (mem_we) begin
          cnt_d   = cnt_q + NW'(1);
          chunk_d = '0;
          rem_d   = '0;
          if ((step_dvd == '0) || (cnt_q >= NW'(MAX_DIGITS - 1))) begin
            idx_d   = cnt_q[AW-1:0];
            state_d = ST_READ;
          end
        end else begin
          chunk_d = chunk_q + CW'(1);
        end
      end
      ST_READ: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q - AW'(1);
            state_d = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      chunk_q <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      chunk_q <= chunk_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    radix_q <= radix_d;
    neg_q   <= neg_d;
  end

  // digit store, least significant digit at address zero
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[cnt_q[AW-1:0]] <= step_rem;
    end
    rd_q <= store_q[idx_q];
  end

  a_emit_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (NW'(idx_q) < cnt_q))
    else $error("emit index outside the stored run");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(MAX_DIGITS))
    else $error("digit count above store depth");

  a_rem_below_radix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < radix_q))
    else $error("partial remainder not below radix");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && !out_ready_i) |=> (state_q == ST_EMIT && $stable(idx_q)))
    else $error("stalled digit was dropped");

endmodule

// ===== sv/integer_to_radix_digits.sv =====
// top level of the integer to radix digit converter
//
//   channel  handshake                 payload
//   -------  ------------------------  ------------------------------------
//   in       in_valid_i / in_ready_o   value_i[63:0] is_signed_i radix_i[5:0]
//   out      out_valid_o / out_ready_i digit_char_o[7:0] negative_o last_o
//
// one request of n digits occupies the digit engine for a division pass per digit,
// then for a store read and a present per digit, most significant digit first;
// presents wait while out_ready_i is low; a new request starts after the last digit
// the division loop retires 8 dividend bits a cycle, not stalled by out_ready_i
// the front end keeps taking requests into a two-entry queue while the engine works
// reset is asynchronous, active low; there is no clearing pass, the digit store is
// only read where the same request has written it
// a stalled digit holds on the output until taken; the queue stalls in_ready_o when full
module integer_to_radix_digits
  import itrd_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned MAX_DIGITS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [63:0]        value_i,
  input  logic               is_signed_i,
  input  logic [RADIX_W-1:0] radix_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CHAR_W-1:0]  digit_char_o,
  output logic               negative_o,
  output logic               last_o
);

  // queued request: negative flag, clamped radix, magnitude
  localparam int unsigned JW = VALUE_BITS + RADIX_W + 1;

  logic [VALUE_BITS-1:0] f_mag;
  logic [RADIX_W-1:0]    f_radix;
  logic                  f_neg;
  logic [JW-1:0]         q_push_data;
  logic [JW-1:0]         q_pop_data;
  logic                  q_pop_valid;
  logic                  q_pop_ready;

  // classification of the request: magnitude, sign and radix clamp
  itrd_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .value_i     (value_i),
    .is_signed_i (is_signed_i),
    .radix_i     (radix_i),
    .job_mag_o   (f_mag),
    .job_radix_o (f_radix),
    .job_neg_o   (f_neg)
  );

  assign q_push_data = {f_neg, f_radix, f_mag};

  // decouples request intake from the digit engine
  itrd_queue #(
    .W(JW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (q_push_data),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_data_o   (q_pop_data)
  );

  // division loop, digit store and most-significant-first emission
  itrd_back #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (q_pop_valid),
    .job_ready_o  (q_pop_ready),
    .job_mag_i    (q_pop_data[VALUE_BITS-1:0]),
    .job_radix_i  (q_pop_data[VALUE_BITS +: RADIX_W]),
    .job_neg_i    (q_pop_data[JW-1]),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digit_char_o (digit_char_o),
    .negative_o   (negative_o),
    .last_o       (last_o)
  );

endmodule

// ===== dv/integer_to_radix_digits_tb.sv =====
// self-checking testbench for the integer to radix digit converter
module integer_to_radix_digits_tb
  import itrd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // cycles without any handshake before the run is declared hung
  localparam int unsigned STALL_LIMIT = 5000;
  // quiet cycles after the last digit, to catch stray outputs
  localparam int unsigned TAIL_CYCLES = 100;
  // receiver hold-off, started once this many requests have gone in
  localparam int unsigned HOLDOFF_AFTER = 40;
  localparam int unsigned HOLDOFF_CYCLES = 700;
  localparam int unsigned RANDOM_REQS = 290;
  // the request at this index waits until every digit has come back
  localparam int unsigned DRAIN_INDEX = 150;

  typedef struct {
    logic [63:0]        value;
    logic               is_signed;
    logic [RADIX_W-1:0] radix;
    bit                 drain_first;
  } conv_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] glyph;
    logic              neg;
    logic              last;
  } digit_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [63:0]        value_i = '0;
  logic               is_signed_i = 1'b0;
  logic [RADIX_W-1:0] radix_i = RADIX_W'(10);
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [CHAR_W-1:0]  digit_char_o;
  logic               negative_o;
  logic               last_o;

  conv_req_t pending_reqs[$];
  digit_t    awaited_digits[$];

  // handshakes seen at the last rising edge, read by the falling-edge drivers
  logic req_taken = 1'b0;
  logic digit_taken = 1'b0;

  int unsigned mismatches = 0;
  int unsigned reqs_accepted = 0;
  int unsigned idle_cycles = 0;

  integer_to_radix_digits uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .is_signed_i (is_signed_i),
    .radix_i     (radix_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .digit_char_o(digit_char_o),
    .negative_o  (negative_o),
    .last_o      (last_o)
  );

  always #2 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: digit check failed: %s", $time, msg);
    mismatches++;
  endtask

  // expected digit run of one request, most significant digit first
  function automatic void convert_to_digits(input logic [63:0] value,
                                            input logic is_signed,
                                            input logic [RADIX_W-1:0] radix);
    logic [RADIX_W-1:0] base;
    logic [63:0]        mag;
    logic               neg;
    logic [RADIX_W-1:0] low_first [64];
    int unsigned        n;
    digit_t             d;
    base = radix;
    // out-of-range radices fold onto the nearest legal one
    if (base < RADIX_W'(MIN_RADIX)) begin
      base = RADIX_W'(MIN_RADIX);
    end
    if (base > RADIX_W'(MAX_RADIX)) begin
      base = RADIX_W'(MAX_RADIX);
    end
    neg = is_signed && value[63];
    // magnitude taken as unsigned, so the most negative value still works
    mag = neg ? (~value + 64'd1) : value;
    n = 0;
    do begin
      low_first[n] = RADIX_W'(mag % 64'(base));
      mag = mag / 64'(base);
      n++;
    end while (mag != 0 && n < 64);
    for (int k = int'(n) - 1; k >= 0; k--) begin
      if (low_first[k] < RADIX_W'(10)) begin
        d.glyph = CHAR_ZERO + CHAR_W'(low_first[k]);
      end else begin
        d.glyph = CHAR_LOW_A + CHAR_W'(low_first[k]) - CHAR_W'(10);
      end
      d.neg = neg;
      d.last = (k == 0);
      awaited_digits.push_back(d);
    end
  endfunction

  task automatic add_req(input logic [63:0] value, input logic is_signed,
                         input logic [RADIX_W-1:0] radix);
    conv_req_t r;
    r.value = value;
    r.is_signed = is_signed;
    r.radix = radix;
    r.drain_first = (pending_reqs.size() == DRAIN_INDEX);
    pending_reqs.push_back(r);
  endtask

  // rising edge: record handshakes, predict accepted requests, check digits
  always @(posedge clk_i) begin
    logic   req_fire;
    logic   digit_fire;
    digit_t exp_d;
    req_fire = in_valid_i && in_ready_o;
    digit_fire = out_valid_o && out_ready_i;
    if (rst_ni) begin
      req_taken <= req_fire;
      digit_taken <= digit_fire;
      // prediction first, in case a request answers in the cycle it is taken
      if (req_fire) begin
        convert_to_digits(value_i, is_signed_i, radix_i);
        reqs_accepted++;
      end
      if (digit_fire) begin
        if (awaited_digits.size() == 0) begin
          report_mismatch($sformatf("unexpected digit %h", digit_char_o));
        end else begin
          exp_d = awaited_digits.pop_front();
          if (digit_char_o !== exp_d.glyph) begin
            report_mismatch($sformatf("digit_char %h, want %h", digit_char_o, exp_d.glyph));
          end
          if (negative_o !== exp_d.neg) begin
            report_mismatch($sformatf("negative %b, want %b", negative_o, exp_d.neg));
          end
          if (last_o !== exp_d.last) begin
            report_mismatch($sformatf("last %b, want %b", last_o, exp_d.last));
          end
        end
      end
      // watchdog on handshake activity
      if (req_fire || digit_fire) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  // request driver: holds valid and payload until taken, random gaps between requests
  bit          send_calm = 1'b0;
  int unsigned send_gap = 0;

  always @(negedge clk_i) begin
    conv_req_t nxt;
    if (rst_ni && !(in_valid_i && !req_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() != 0 &&
                   !(pending_reqs[0].drain_first && awaited_digits.size() != 0)) begin
        nxt = pending_reqs.pop_front();
        value_i <= nxt.value;
        is_signed_i <= nxt.is_signed;
        radix_i <= nxt.radix;
        in_valid_i <= 1'b1;
        // occasionally switch between back-to-back and gappy stretches
        if ($urandom_range(0, 24) == 0) begin
          send_calm = ~send_calm;
        end
        send_gap = send_calm ? 0 : $urandom_range(0, 7);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // digit receiver: random stall per digit plus one long hold-off
  bit          recv_calm = 1'b0;
  bit          holdoff_done = 1'b0;
  int unsigned holdoff_left = 0;
  int unsigned recv_wait = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      // long hold-off while the sender keeps offering, so the input queue fills
      if (!holdoff_done && reqs_accepted >= HOLDOFF_AFTER) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (digit_taken) begin
        if ($urandom_range(0, 29) == 0) begin
          recv_calm = ~recv_calm;
        end
        recv_wait = recv_calm ? 0 : $urandom_range(0, 7);
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready_i <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    logic [63:0]        v;
    logic [RADIX_W-1:0] r;

    // directed: zero, extremes of value and radix, folded radices
    add_req(64'd0, 1'b0, RADIX_W'(10));
    add_req(64'd0, 1'b1, RADIX_W'(2));
    add_req('1, 1'b0, RADIX_W'(2));                  // 64 binary digits
    add_req('1, 1'b1, RADIX_W'(10));                 // minus one
    add_req(64'h8000_0000_0000_0000, 1'b1, RADIX_W'(2));  // most negative
    add_req(64'h8000_0000_0000_0000, 1'b1, RADIX_W'(10));
    add_req(64'h8000_0000_0000_0000, 1'b0, RADIX_W'(16));
    add_req(64'h7fff_ffff_ffff_ffff, 1'b1, RADIX_W'(36));
    add_req('1, 1'b0, RADIX_W'(36));
    add_req(64'd35, 1'b0, RADIX_W'(36));
    add_req(64'd10, 1'b0, RADIX_W'(36));
    add_req(64'd9, 1'b0, RADIX_W'(10));
    add_req(64'd255, 1'b0, RADIX_W'(16));
    add_req(64'd1234567, 1'b1, RADIX_W'(10));        // signed but positive
    add_req(64'd5, 1'b0, RADIX_W'(0));               // radix below two
    add_req(64'd6, 1'b1, RADIX_W'(1));
    add_req(64'd12345, 1'b0, RADIX_W'(37));          // radix above thirty-six
    add_req(-64'd12345, 1'b1, '1);
    add_req(64'h0123_4567_89ab_cdef, 1'b0, RADIX_W'(8));
    add_req(64'd80, 1'b0, RADIX_W'(3));
    add_req('1, 1'b0, RADIX_W'(1));

    // random requests
    for (int i = 0; i < RANDOM_REQS; i++) begin
      v = {$urandom, $urandom};
      case ($urandom_range(0, 3))
        0: ;
        1: v = v >> $urandom_range(0, 63);
        2: v = 64'($urandom_range(0, 1000));
        default: v = -64'($urandom_range(1, 100000));
      endcase
      if ($urandom_range(0, 6) == 0) begin
        r = RADIX_W'($urandom_range(0, 63));
      end else begin
        r = RADIX_W'($urandom_range(MIN_RADIX, MAX_RADIX));
      end
      add_req(v, 1'($urandom_range(0, 1)), r);
    end

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    do begin
      @(posedge clk_i);
    end while (pending_reqs.size() != 0 || in_valid_i || awaited_digits.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (awaited_digits.size() != 0) begin
      report_mismatch($sformatf("%0d digits never arrived", awaited_digits.size()));
    end
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/itrd_pkg.sv
sv/itrd_front.sv
sv/itrd_queue.sv
sv/itrd_back.sv
sv/integer_to_radix_digits.sv
dv/integer_to_radix_digits_tb.sv
